@@ rtl/srs_pkg.sv @@
// Shared types and constants of the scaled roulette selection block.
`default_nettype none
package srs_pkg;

	localparam int unsigned POP_MAX = 64;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned FIT_W   = 32;
	localparam int unsigned SUM_W   = 38;
	localparam int unsigned TOT_W   = 40;
	localparam int unsigned DVD_W   = 56;
	localparam int unsigned DVS_W   = 32;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SCALE  = 2'd1;
	localparam logic [1:0] OP_SELECT = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EQUAL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic CFG_POP = 1'b0;
	localparam logic CFG_LAM = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD,
		S_SCAN_RD, S_SCAN_ACC, S_SCAN_END, S_MEAN_WAIT,
		S_COEF_AB, S_COEF_MUL, S_COEF_SEL,
		S_SC_RD, S_SC_SUB, S_SC_MUL, S_SC_DIV, S_SC_WAIT, S_SC_WR, S_SC_END,
		S_SEL_MUL, S_SEL_RD, S_SEL_ACC,
		S_RESP
	} state_t;

	typedef struct packed {
		logic latch;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic load_wr;
		logic scan_acc;
		logic div_mean;
		logic mean_ld;
		logic coef_ab;
		logic coef_mul;
		logic coef_sel;
		logic sc_sub;
		logic sc_mul;
		logic div_elem;
		logic sc_wr;
		logic tot_ld;
		logic st_eq;
		logic sel_init;
		logic sel_acc;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic all_eq;
		logic div_done;
		logic sel_hit;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/scaled_roulette_selection_core.sv @@
// Top level of the scaled roulette selection block.
//
// A request is taken when start is high and busy is low; its one result
// (chosen_index, status) stands for exactly one cycle with done high and is
// never held off. A select walks the table slot by slot through the single
// table read port. A scale makes a statistics pass, then finds the mean and
// the coefficients, then scales each slot in turn, each scaled value needing
// the 56-step bit-serial divider; a slot waits until the divider is done.
// Configuration writes are always ready and must be made while busy is low.
`default_nettype none
module scaled_roulette_selection_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [5:0]  slot,
	input  wire logic [31:0] fitness_in,
	input  wire logic [15:0] random_fraction,
	output logic             done,
	output logic [5:0]       chosen_index,
	output logic [1:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);
	srs_pkg::cmd_t  cmd;
	srs_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	srs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	srs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.slot            (slot),
		.fitness_in      (fitness_in),
		.random_fraction (random_fraction),
		.chosen_index    (chosen_index),
		.status          (status)
	);

	// a result only appears while a request is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a request");

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	// one result per request: the strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

	// a result is only ever followed by the idle state
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("block still busy after its result");
endmodule
`default_nettype wire

@@ rtl/srs_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module srs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/srs_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module srs_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [srs_pkg::DVD_W-1:0] dividend,
	input  wire logic [srs_pkg::DVS_W-1:0] divisor,
	output logic                           done,
	output logic      [srs_pkg::DVD_W-1:0] quot,
	output logic      [srs_pkg::DVS_W-1:0] rem
);
	localparam int unsigned CNT_W = $clog2(srs_pkg::DVD_W);

	logic [srs_pkg::DVS_W-1:0] div_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [srs_pkg::DVS_W:0]   trial;
	logic [srs_pkg::DVS_W:0]   diff;
	logic                      take;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem, quot[srs_pkg::DVD_W-1]};
		diff  = trial - {1'b0, div_q};
		take  = (trial >= {1'b0, div_q});
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(srs_pkg::DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// advance the quotient and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			quot  <= dividend;
			rem   <= '0;
		end else if (run_q) begin
			rem  <= take ? diff[srs_pkg::DVS_W-1:0] : trial[srs_pkg::DVS_W-1:0];
			quot <= {quot[srs_pkg::DVD_W-2:0], take};
		end
	end

	assign done = done_q;
endmodule
`default_nettype wire

@@ rtl/srs_datapath.sv @@
// Datapath: fitness table, statistics, scaling arithmetic and selection walk.
`default_nettype none
module srs_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire srs_pkg::cmd_t             cmd,
	output srs_pkg::stat_t                 stat,
	input  wire logic                      cfg_valid,
	input  wire logic                      cfg_index,
	input  wire logic [7:0]                cfg_data,
	input  wire logic [srs_pkg::IDX_W-1:0] slot,
	input  wire logic [srs_pkg::FIT_W-1:0] fitness_in,
	input  wire logic [15:0]               random_fraction,
	output logic      [srs_pkg::IDX_W-1:0] chosen_index,
	output logic      [1:0]                status
);
	localparam int unsigned IW = srs_pkg::IDX_W;
	localparam int unsigned FW = srs_pkg::FIT_W;
	localparam int unsigned SW = srs_pkg::SUM_W;
	localparam int unsigned TW = srs_pkg::TOT_W;

	logic [6:0]              pop_q;
	logic [7:0]              lam_q;
	logic [IW-1:0]           slot_q;
	logic [FW-1:0]           fit_q;
	logic [15:0]             frac_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           chosen_q;
	logic [1:0]              status_q;
	logic [srs_pkg::POP_MAX-1:0] valid_q;
	logic                    rd_vld_q;
	logic [FW-1:0]           ram_rdata;
	logic signed [SW-1:0]    sum_q;
	logic signed [FW-1:0]    best_q;
	logic signed [FW-1:0]    worst_q;
	logic signed [FW-1:0]    mean_q;
	logic                    mneg_q;
	logic [31:0]             a_q;
	logic [31:0]             b_q;
	logic [39:0]             cprod_q;
	logic [7:0]              num_q;
	logic [31:0]             den_q;
	logic                    dneg_q;
	logic [31:0]             dmag_q;
	logic [39:0]             prod_q;
	logic signed [TW-1:0]    total_q;
	logic signed [56:0]      slice_q;
	logic signed [SW-1:0]    run_q;

	logic [6:0]              n_eff;
	logic                    in_range;
	logic [7:0]              lm1;
	logic signed [FW-1:0]    f;
	logic [SW-1:0]           sum_mag;
	logic                    div_start;
	logic [srs_pkg::DVD_W-1:0] dvd;
	logic [srs_pkg::DVS_W-1:0] dvs;
	logic                    div_done;
	logic [srs_pkg::DVD_W-1:0] quot;
	logic [srs_pkg::DVS_W-1:0] rem;
	logic signed [32:0]      mean33;
	logic signed [32:0]      da;
	logic signed [32:0]      db;
	logic signed [32:0]      dd;
	logic signed [57:0]      qs;
	logic signed [57:0]      vv;
	logic signed [FW-1:0]    v32;
	logic signed [SW-1:0]    run_new;
	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	logic [FW-1:0]           ram_wdata;

	// clamp the size and lambda registers
	always_comb begin
		if (pop_q == 7'd0) begin
			n_eff = 7'd1;
		end else if (pop_q > 7'(srs_pkg::POP_MAX)) begin
			n_eff = 7'(srs_pkg::POP_MAX);
		end else begin
			n_eff = pop_q;
		end
		lm1 = ((lam_q < 8'd2) ? 8'd2 : lam_q) - 8'd1;
	end

	assign in_range = ({1'b0, slot_q} < n_eff);
	assign f        = rd_vld_q ? $signed(ram_rdata) : '0;
	assign sum_mag  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	// divider operand selection
	assign div_start = cmd.div_mean | cmd.div_elem;
	assign dvd = cmd.div_elem ? {prod_q, 16'b0} : {{(srs_pkg::DVD_W - SW){1'b0}}, sum_mag};
	assign dvs = cmd.div_elem ? den_q : {25'b0, n_eff};

	srs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	// floor the mean; form the spreads, element difference and saturated scaled value
	always_comb begin
		mean33 = mneg_q ? (-$signed({1'b0, quot[31:0]}) - $signed({32'b0, rem != '0}))
		                : $signed({1'b0, quot[31:0]});
		da  = $signed({mean_q[FW-1], mean_q}) - $signed({worst_q[FW-1], worst_q});
		db  = $signed({best_q[FW-1], best_q}) - $signed({mean_q[FW-1], mean_q});
		dd  = $signed({f[FW-1], f}) - $signed({mean_q[FW-1], mean_q});
		qs  = dneg_q ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
		vv  = qs + 58'sd65536;
		if (vv > 58'sd2147483647) begin
			v32 = 32'sh7FFF_FFFF;
		end else if (vv < -58'sd2147483648) begin
			v32 = 32'sh8000_0000;
		end else begin
			v32 = vv[FW-1:0];
		end
		run_new = run_q + {{(SW - FW){f[FW-1]}}, f};
	end

	// table write port
	assign ram_we    = (cmd.load_wr & in_range) | cmd.sc_wr;
	assign ram_waddr = cmd.load_wr ? slot_q : idx_q;
	assign ram_wdata = cmd.load_wr ? fit_q : v32;

	srs_ram #(.WIDTH(FW), .DEPTH(srs_pkg::POP_MAX)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// control state: configuration, valid bits, index and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q    <= 7'd64;
			lam_q    <= 8'd10;
			valid_q  <= '0;
			idx_q    <= '0;
			chosen_q <= '0;
			status_q <= srs_pkg::ST_OK;
			total_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					srs_pkg::CFG_POP: pop_q <= cfg_data[6:0];
					srs_pkg::CFG_LAM: lam_q <= cfg_data;
					default: ;
				endcase
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.latch) begin
				chosen_q <= '0;
				status_q <= srs_pkg::ST_OK;
			end
			if (cmd.load_wr && !in_range) begin
				status_q <= srs_pkg::ST_RANGE;
			end
			if (cmd.st_eq) begin
				status_q <= srs_pkg::ST_EQUAL;
			end
			if (cmd.sel_acc) begin
				chosen_q <= idx_q;
			end
			if (cmd.tot_ld) begin
				total_q <= {{(TW - SW){sum_q[SW-1]}}, sum_q};
			end
		end
	end

	// payload registers of the arithmetic
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			slot_q <= slot;
			fit_q  <= fitness_in;
			frac_q <= random_fraction;
			sum_q  <= '0;
		end
		if (cmd.rd_en) begin
			rd_vld_q <= valid_q[idx_q];
		end
		if (cmd.scan_acc) begin
			sum_q <= sum_q + {{(SW - FW){f[FW-1]}}, f};
			if (idx_q == '0 || f > best_q) begin
				best_q <= f;
			end
			if (idx_q == '0 || f < worst_q) begin
				worst_q <= f;
			end
		end
		if (cmd.div_mean) begin
			mneg_q <= sum_q[SW-1];
		end
		if (cmd.mean_ld) begin
			mean_q <= mean33[FW-1:0];
		end
		if (cmd.coef_ab) begin
			a_q <= da[31:0];
			b_q <= db[31:0];
		end
		if (cmd.coef_mul) begin
			cprod_q <= 40'(lm1) * 40'(a_q);
		end
		if (cmd.coef_sel) begin
			sum_q <= '0;
			if (a_q != '0 && {8'b0, b_q} >= cprod_q) begin
				num_q <= 8'd1;
				den_q <= a_q;
			end else begin
				num_q <= lm1;
				den_q <= b_q;
			end
		end
		if (cmd.sc_sub) begin
			dneg_q <= dd[32];
			dmag_q <= dd[32] ? 32'(-dd) : dd[31:0];
		end
		if (cmd.sc_mul) begin
			prod_q <= 40'(dmag_q) * 40'(num_q);
		end
		if (cmd.sc_wr) begin
			sum_q <= sum_q + {{(SW - FW){v32[FW-1]}}, v32};
		end
		if (cmd.sel_init) begin
			slice_q <= $signed({41'b0, frac_q}) * $signed({{17{total_q[TW-1]}}, total_q});
			run_q   <= '0;
		end
		if (cmd.sel_acc) begin
			run_q <= run_new;
		end
	end

	// status back to the controller
	always_comb begin
		stat.last     = ({1'b0, idx_q} == (n_eff - 7'd1));
		stat.all_eq   = (best_q == worst_q);
		stat.div_done = div_done;
		stat.sel_hit  = ($signed({{3{run_new[SW-1]}}, run_new, 16'b0}) >= slice_q);
	end

	assign chosen_index = chosen_q;
	assign status       = status_q;
endmodule
`default_nettype wire

@@ rtl/srs_ctrl.sv @@
// Controller state machine sequencing load, scale and select requests.
`default_nettype none
module srs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     op,
	input  wire srs_pkg::stat_t stat,
	output srs_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);
	srs_pkg::state_t state_q, state_d;

	// hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srs_pkg::S_IDLE: begin
				if (start) begin
					case (op)
						srs_pkg::OP_LOAD:   state_d = srs_pkg::S_LOAD;
						srs_pkg::OP_SCALE:  state_d = srs_pkg::S_SCAN_RD;
						srs_pkg::OP_SELECT: state_d = srs_pkg::S_SEL_MUL;
						default:            state_d = srs_pkg::S_RESP;
					endcase
				end
			end
			srs_pkg::S_LOAD:     state_d = srs_pkg::S_RESP;
			srs_pkg::S_SCAN_RD:  state_d = srs_pkg::S_SCAN_ACC;
			srs_pkg::S_SCAN_ACC: state_d = stat.last ? srs_pkg::S_SCAN_END : srs_pkg::S_SCAN_RD;
			srs_pkg::S_SCAN_END: state_d = stat.all_eq ? srs_pkg::S_RESP : srs_pkg::S_MEAN_WAIT;
			srs_pkg::S_MEAN_WAIT: begin
				if (stat.div_done) begin
					state_d = srs_pkg::S_COEF_AB;
				end
			end
			srs_pkg::S_COEF_AB:  state_d = srs_pkg::S_COEF_MUL;
			srs_pkg::S_COEF_MUL: state_d = srs_pkg::S_COEF_SEL;
			srs_pkg::S_COEF_SEL: state_d = srs_pkg::S_SC_RD;
			srs_pkg::S_SC_RD:    state_d = srs_pkg::S_SC_SUB;
			srs_pkg::S_SC_SUB:   state_d = srs_pkg::S_SC_MUL;
			srs_pkg::S_SC_MUL:   state_d = srs_pkg::S_SC_DIV;
			srs_pkg::S_SC_DIV:   state_d = srs_pkg::S_SC_WAIT;
			srs_pkg::S_SC_WAIT: begin
				if (stat.div_done) begin
					state_d = srs_pkg::S_SC_WR;
				end
			end
			srs_pkg::S_SC_WR:    state_d = stat.last ? srs_pkg::S_SC_END : srs_pkg::S_SC_RD;
			srs_pkg::S_SC_END:   state_d = srs_pkg::S_RESP;
			srs_pkg::S_SEL_MUL:  state_d = srs_pkg::S_SEL_RD;
			srs_pkg::S_SEL_RD:   state_d = srs_pkg::S_SEL_ACC;
			srs_pkg::S_SEL_ACC: begin
				state_d = (stat.sel_hit || stat.last) ? srs_pkg::S_RESP : srs_pkg::S_SEL_RD;
			end
			srs_pkg::S_RESP:     state_d = srs_pkg::S_IDLE;
			default:             state_d = srs_pkg::S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd  = '0;
		busy = (state_q != srs_pkg::S_IDLE);
		done = 1'b0;
		unique case (state_q)
			srs_pkg::S_IDLE: begin
				cmd.latch   = start;
				cmd.idx_clr = start;
			end
			srs_pkg::S_LOAD:     cmd.load_wr = 1'b1;
			srs_pkg::S_SCAN_RD:  cmd.rd_en = 1'b1;
			srs_pkg::S_SCAN_ACC: begin
				cmd.scan_acc = 1'b1;
				cmd.idx_inc  = !stat.last;
			end
			srs_pkg::S_SCAN_END: begin
				cmd.tot_ld   = stat.all_eq;
				cmd.st_eq    = stat.all_eq;
				cmd.div_mean = !stat.all_eq;
			end
			srs_pkg::S_MEAN_WAIT: cmd.mean_ld = stat.div_done;
			srs_pkg::S_COEF_AB:  cmd.coef_ab = 1'b1;
			srs_pkg::S_COEF_MUL: cmd.coef_mul = 1'b1;
			srs_pkg::S_COEF_SEL: begin
				cmd.coef_sel = 1'b1;
				cmd.idx_clr  = 1'b1;
			end
			srs_pkg::S_SC_RD:    cmd.rd_en = 1'b1;
			srs_pkg::S_SC_SUB:   cmd.sc_sub = 1'b1;
			srs_pkg::S_SC_MUL:   cmd.sc_mul = 1'b1;
			srs_pkg::S_SC_DIV:   cmd.div_elem = 1'b1;
			srs_pkg::S_SC_WAIT:  ;
			srs_pkg::S_SC_WR: begin
				cmd.sc_wr   = 1'b1;
				cmd.idx_inc = !stat.last;
			end
			srs_pkg::S_SC_END:   cmd.tot_ld = 1'b1;
			srs_pkg::S_SEL_MUL:  cmd.sel_init = 1'b1;
			srs_pkg::S_SEL_RD:   cmd.rd_en = 1'b1;
			srs_pkg::S_SEL_ACC: begin
				cmd.sel_acc = 1'b1;
				cmd.idx_inc = !(stat.sel_hit || stat.last);
			end
			srs_pkg::S_RESP:     done = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire
